// ----- hdl/blhq_pkg.sv -----
// Shared types and constants for the battery level hysteresis quantizer.
package blhq_pkg;

    // Field and register widths
    localparam int SAMP_W  = 16;
    localparam int LEVEL_W = 4;
    localparam int CELL_W  = 4;
    localparam int LVC_W   = 5;
    localparam int HYS_W   = 12;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 12;

    // Threshold storage (signed mV) and the wider compare width
    localparam int THR_W   = 18;
    localparam int CMP_W   = 20;

    // Q16 ratio, up to and including 1.0
    localparam int RATIO_W = 17;
    // Remainder of a division by at most 30
    localparam int REM_W   = 5;

    // floor(r*6/5) as (r * 6 * ceil(2^22/5)) >> 22, exact for every 17-bit ratio
    localparam int            BOOST_SH  = 22;
    localparam int            BPROD_W   = 40;
    localparam logic [22:0]   BOOST_MUL = 23'd5033166;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_CELL_COUNT  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_LEVEL_COUNT = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_HYSTERESIS  = 2'd2;

    // Opcodes
    localparam logic OP_INIT     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_BUILD,
        TS_SCAN,
        TS_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PREP,
        BS_DIV,
        BS_BOOST,
        BS_MUL,
        BS_WRITE
    } t_bld_state;

    typedef enum logic [1:0] {
        SS_IDLE,
        SS_SCAN,
        SS_ZERO,
        SS_DECIDE
    } t_scn_state;

endpackage

// ----- hdl/blhq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module blhq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, then registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/blhq_build.sv -----
// Threshold table builder: ratio divider, boost and scale multipliers, table writes.
module blhq_build
    import blhq_pkg::*;
#(
    parameter int MAX_CELLS     = 8,
    parameter int MAX_LEVELS    = 16,
    parameter int CELL_FULL_MV  = 4200,
    parameter int CELL_EMPTY_MV = 3000,
    parameter int IDX_W         = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [CELL_W-1:0]       i_cell_count,
    input  logic [LVC_W-1:0]        i_level_count,
    output logic                    o_we,
    output logic [IDX_W-1:0]        o_waddr,
    output logic [THR_W-1:0]        o_wdata,
    output logic                    o_done,
    output logic [LVC_W-1:0]        o_levels
);

    t_bld_state r_state, n_state;

    logic signed [THR_W-1:0]   r_full, r_empty, r_range;
    logic [LVC_W-1:0]          r_lv, r_d, r_idx;
    logic [4:0]                r_bit;
    logic [REM_W-1:0]          r_rem, r_acc;
    logic [RATIO_W-1:0]        r_q0, r_q;
    logic [BPROD_W-1:0]        r_bprod;
    logic                      r_boost;
    logic signed [2*THR_W-1:0] r_tprod;

    logic [CELL_W-1:0]         cells;
    logic [LVC_W-1:0]          lv;
    logic [REM_W:0]            rem_sh;
    logic                      rem_ge;
    logic [REM_W:0]            acc_sum;
    logic                      last_idx;
    logic [RATIO_W-1:0]        ratio_b;
    logic signed [2*THR_W-1:0] tprod_bias;
    logic signed [CMP_W-1:0]   scaled, thr_sum, full_ext;

    // Clamp the configured counts to their usable ranges
    always_comb begin
        if (i_cell_count == '0) begin
            cells = CELL_W'(1);
        end else if (int'(i_cell_count) > MAX_CELLS) begin
            cells = CELL_W'(MAX_CELLS);
        end else begin
            cells = i_cell_count;
        end
        if (i_level_count < LVC_W'(2)) begin
            lv = LVC_W'(2);
        end else if (int'(i_level_count) > MAX_LEVELS) begin
            lv = LVC_W'(MAX_LEVELS);
        end else begin
            lv = i_level_count;
        end
    end

    // One restoring step of 65536 / d
    assign rem_sh = {r_rem, (r_bit == 5'd16)};
    assign rem_ge = (rem_sh >= {1'b0, r_d});

    // Step the ratio by 65536/d without dividing again
    assign acc_sum  = {1'b0, r_acc} + {1'b0, r_rem};
    assign last_idx = (r_idx == r_d);

    // Pick the boosted ratio, then truncate the scaled product toward zero
    assign ratio_b    = r_boost ? r_bprod[BOOST_SH +: RATIO_W] : r_q;
    assign tprod_bias = r_tprod + (r_tprod[2*THR_W-1] ? (2*THR_W)'(65535) : '0);
    assign scaled     = tprod_bias[16 +: CMP_W];
    assign full_ext   = CMP_W'(r_full);
    assign thr_sum    = CMP_W'(r_empty) + scaled;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE:  if (i_start) n_state = BS_PREP;
            BS_PREP:  n_state = BS_DIV;
            BS_DIV:   if (r_bit == '0) n_state = BS_BOOST;
            BS_BOOST: n_state = BS_MUL;
            BS_MUL:   n_state = BS_WRITE;
            BS_WRITE: n_state = last_idx ? BS_IDLE : BS_BOOST;
            default:  n_state = BS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_we    = (r_state == BS_WRITE);
        o_done  = (r_state == BS_WRITE) && last_idx;
        o_waddr = IDX_W'(r_idx);
        o_wdata = (thr_sum > full_ext) ? THR_W'(full_ext) : THR_W'(thr_sum);
    end

    assign o_levels = r_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                r_bit <= 5'd16;
            end
            BS_PREP: begin
                r_full  <= THR_W'(int'(cells) * CELL_FULL_MV);
                r_empty <= THR_W'(int'(cells) * CELL_EMPTY_MV);
                r_range <= THR_W'(int'(cells) * (CELL_FULL_MV - CELL_EMPTY_MV));
                r_lv    <= lv;
                r_d     <= lv - LVC_W'(1);
                r_rem   <= '0;
                r_q0    <= '0;
                r_bit   <= 5'd16;
            end
            BS_DIV: begin
                r_rem <= rem_ge ? REM_W'(rem_sh - {1'b0, r_d}) : REM_W'(rem_sh);
                r_q0  <= {r_q0[RATIO_W-2:0], rem_ge};
                r_bit <= r_bit - 5'd1;
                r_q   <= '0;
                r_acc <= '0;
                r_idx <= '0;
            end
            BS_BOOST: begin
                r_bprod <= BPROD_W'(r_q) * BPROD_W'(BOOST_MUL);
                r_boost <= (9'(r_idx) * 9'd10) < (9'(r_d) * 9'd3);
            end
            BS_MUL: begin
                r_tprod <= $signed({1'b0, ratio_b}) * r_range;
            end
            BS_WRITE: begin
                r_idx <= r_idx + LVC_W'(1);
                if (acc_sum >= {1'b0, r_d}) begin
                    r_acc <= REM_W'(acc_sum - {1'b0, r_d});
                    r_q   <= r_q + r_q0 + RATIO_W'(1);
                end else begin
                    r_acc <= REM_W'(acc_sum);
                    r_q   <= r_q + r_q0;
                end
            end
            default: begin
                r_bit <= 5'd16;
            end
        endcase
    end

endmodule

// ----- hdl/blhq_scan.sv -----
// Classifier: walks the threshold memory downward and applies hysteresis.
module blhq_scan
    import blhq_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SAMP_W-1:0]  i_sample,
    input  logic [LVC_W-1:0]   i_levels,
    input  logic [HYS_W-1:0]   i_hyst,
    input  logic [IDX_W-1:0]   i_last,
    output logic [IDX_W-1:0]   o_raddr,
    input  logic [THR_W-1:0]   i_rdata,
    output logic               o_done,
    output logic [IDX_W-1:0]   o_cur
);

    t_scn_state r_state, n_state;

    logic [IDX_W-1:0]        r_idx, r_pidx, r_cur;
    logic                    r_pv;
    logic [SAMP_W-1:0]       r_sample;
    logic signed [THR_W-1:0] r_thr;

    logic signed [CMP_W-1:0] samp, rd_ext, thr_ext, hyst_ext;
    logic                    hit, bottom, hold;

    assign samp     = $signed(CMP_W'(r_sample));
    assign rd_ext   = CMP_W'($signed(i_rdata));
    assign thr_ext  = CMP_W'(r_thr);
    assign hyst_ext = $signed(CMP_W'(i_hyst));
    assign hit      = r_pv && (samp >= rd_ext);
    assign bottom   = r_pv && (r_pidx == IDX_W'(1));

    // Keep the old level unless the sample clears the band around the threshold
    always_comb begin
        hold = 1'b0;
        if (r_cur > i_last) begin
            hold = (samp <= thr_ext + hyst_ext);
        end else if (r_cur < i_last) begin
            hold = (samp >= thr_ext - hyst_ext);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SS_IDLE: if (i_start) n_state = SS_SCAN;
            SS_SCAN: begin
                if (hit) begin
                    n_state = SS_DECIDE;
                end else if (bottom) begin
                    n_state = SS_ZERO;
                end
            end
            SS_ZERO:   n_state = SS_DECIDE;
            SS_DECIDE: n_state = SS_IDLE;
            default:   n_state = SS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_raddr = r_idx;
        o_done  = (r_state == SS_DECIDE);
        o_cur   = hold ? i_last : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Issue one read per cycle and check the previous one
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SS_IDLE: begin
                r_idx    <= IDX_W'(i_levels - LVC_W'(1));
                r_pv     <= 1'b0;
                r_sample <= i_sample;
            end
            SS_SCAN: begin
                r_idx  <= r_idx - IDX_W'(1);
                r_pidx <= r_idx;
                r_pv   <= 1'b1;
                if (hit) begin
                    r_cur <= r_pidx;
                    r_thr <= $signed(i_rdata);
                end
            end
            SS_ZERO: begin
                r_cur <= '0;
                r_thr <= $signed(i_rdata);
            end
            default: begin
                r_pv <= 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/battery_level_hysteresis_quantizer.sv -----
// Top level: stream ports, configuration registers, threshold memory and control.
// Initialize word: ratio divide, then a boost, multiply and write step per level.
// Classify word: walks the threshold memory down from the top level to the first hit
//   or to level 0, one read per cycle, then makes the hysteresis decision.
// One word is in work at a time; a new word is taken while a result waits at the output.
// Synchronous active-low reset clears control, registers to cell_count 1, level_count 2,
//   hysteresis 0, level 0; the threshold memory holds nothing until the first initialize.
module battery_level_hysteresis_quantizer
    import blhq_pkg::*;
#(
    parameter int MAX_CELLS     = 8,
    parameter int MAX_LEVELS    = 16,
    parameter int CELL_FULL_MV  = 4200,
    parameter int CELL_EMPTY_MV = 3000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [15:0]        i_s_axis_tdata,   // [15:0] sample_mv
    input  logic [0:0]         i_s_axis_tuser,   // [0] opcode
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [3:0] level, [7:4] zero
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_D_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_LEVELS);

    t_top_state r_state, n_state;

    logic [CELL_W-1:0]  r_cell_count;
    logic [LVC_W-1:0]   r_level_count;
    logic [HYS_W-1:0]   r_hyst;
    logic [IDX_W-1:0]   r_last_level;
    logic [LVC_W-1:0]   r_levels_in_use;
    logic [LEVEL_W-1:0] r_res;
    logic               r_ov;
    logic [7:0]         r_odata;

    logic               in_acc, bld_start, scn_start, out_load;
    logic               bld_we, bld_done, scn_done;
    logic [IDX_W-1:0]   bld_waddr, scn_raddr, scn_cur;
    logic [THR_W-1:0]   bld_wdata, ram_rdata;
    logic [LVC_W-1:0]   bld_levels;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign bld_start = in_acc && (i_s_axis_tuser[0] == OP_INIT);
    assign scn_start = in_acc && (i_s_axis_tuser[0] == OP_CLASSIFY);
    assign out_load  = (r_state == TS_OUT) && (!r_ov || i_m_axis_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: begin
                if (bld_start) begin
                    n_state = TS_BUILD;
                end else if (scn_start) begin
                    n_state = TS_SCAN;
                end
            end
            TS_BUILD: if (bld_done) n_state = TS_OUT;
            TS_SCAN:  if (scn_done) n_state = TS_OUT;
            TS_OUT:   if (out_load) n_state = TS_IDLE;
            default:  n_state = TS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_axis_tready = (r_state == TS_IDLE);
        o_m_axis_tvalid = r_ov;
        o_m_axis_tdata  = r_odata;
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= TS_IDLE;
            r_ov            <= 1'b0;
            r_cell_count    <= CELL_W'(1);
            r_level_count   <= LVC_W'(2);
            r_hyst          <= '0;
            r_last_level    <= '0;
            r_levels_in_use <= LVC_W'(2);
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CELL_COUNT:  r_cell_count  <= i_cfg_wdata[CELL_W-1:0];
                    CFG_LEVEL_COUNT: r_level_count <= i_cfg_wdata[LVC_W-1:0];
                    CFG_HYSTERESIS:  r_hyst        <= i_cfg_wdata[HYS_W-1:0];
                    default: ;
                endcase
            end
            if (bld_done) begin
                r_last_level    <= '0;
                r_levels_in_use <= bld_levels;
            end else if (scn_done) begin
                r_last_level <= scn_cur;
            end
        end
    end

    // Hold the result, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (bld_done) begin
            r_res <= '0;
        end else if (scn_done) begin
            r_res <= LEVEL_W'(scn_cur);
        end
        if (out_load) begin
            r_odata <= {4'b0000, r_res};
        end
    end

    blhq_ram #(
        .WIDTH (THR_W),
        .DEPTH (MAX_LEVELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (bld_we),
        .i_waddr (bld_waddr),
        .i_wdata (bld_wdata),
        .i_raddr (scn_raddr),
        .o_rdata (ram_rdata)
    );

    blhq_build #(
        .MAX_CELLS     (MAX_CELLS),
        .MAX_LEVELS    (MAX_LEVELS),
        .CELL_FULL_MV  (CELL_FULL_MV),
        .CELL_EMPTY_MV (CELL_EMPTY_MV),
        .IDX_W         (IDX_W)
    ) u_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (bld_start),
        .i_cell_count  (r_cell_count),
        .i_level_count (r_level_count),
        .o_we          (bld_we),
        .o_waddr       (bld_waddr),
        .o_wdata       (bld_wdata),
        .o_done        (bld_done),
        .o_levels      (bld_levels)
    );

    blhq_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scn_start),
        .i_sample (i_s_axis_tdata),
        .i_levels (r_levels_in_use),
        .i_hyst   (r_hyst),
        .i_last   (r_last_level),
        .o_raddr  (scn_raddr),
        .i_rdata  (ram_rdata),
        .o_done   (scn_done),
        .o_cur    (scn_cur)
    );

    // Builder and classifier never finish together
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(bld_done && scn_done))
        else $error("builder and classifier finished in the same cycle");

    // An initialize clears the remembered level
    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bld_done |=> (r_last_level == '0) && (r_res == '0))
        else $error("remembered level not cleared by initialize");

    // A finished item reaches the output register before the next is taken
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bld_done || scn_done) |=> (r_state == TS_OUT) && !o_s_axis_tready)
        else $error("result not held for the output register");

endmodule

// ----- bench/tb_battery_level_hysteresis_quantizer.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the battery level quantizer: a directed plan, then random phases.
module tb_battery_level_hysteresis_quantizer;
    import blhq_pkg::*;

    localparam int CELLS_MAX    = 8;
    localparam int LEVELS_MAX   = 16;
    localparam int FULL_MV      = 4200;
    localparam int EMPTY_MV     = 3000;
    localparam int RANDOM_WORDS = 800;
    localparam int STALL_PCT    = 27;
    localparam int WATCHDOG     = 3000;
    localparam int TAIL_CYCLES  = 40;
    localparam int SHOW_LIMIT   = 10;
    // Index with no register behind it
    localparam logic [CFG_A_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] arg_a;    // register index, or opcode
        logic [15:0] arg_b;    // register value, or sample in mV
        logic        fixed;    // level below is typed in by hand
        logic [3:0]  level;
    } plan_row_t;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [15:0]         s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tready  = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr  = '0;
    logic [CFG_D_W-1:0]  cfg_wdata = '0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [7:0]          m_tdata;

    // Shadow copy of the block: registers, threshold table, held level
    logic [CELL_W-1:0]   reg_cells  = 4'd1;
    logic [LVC_W-1:0]    reg_levels = 5'd2;
    logic [HYS_W-1:0]    reg_hyst   = '0;
    int                  thr_mv [LEVELS_MAX];
    int                  held_level     = 0;
    int                  levels_latched = 2;

    logic [3:0]          pending_levels [$];
    logic [3:0]          level_want;
    int                  words_sent   = 0;
    int                  mismatches   = 0;
    int                  quiet_cycles = 0;
    logic                calm;

    battery_level_hysteresis_quantizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Run without any idling over a stretch of the random part
    assign calm = (words_sent >= 350) && (words_sent < 520);

    // Build the per-level thresholds from the current registers
    function automatic void load_thresholds();
        longint cells, lv, full, empty, span, ratio, t;
        cells = reg_cells;
        if (cells < 1) cells = 1;
        if (cells > CELLS_MAX) cells = CELLS_MAX;
        lv = reg_levels;
        if (lv < 2) lv = 2;
        if (lv > LEVELS_MAX) lv = LEVELS_MAX;
        full  = cells * FULL_MV;
        empty = cells * EMPTY_MV;
        span  = full - empty;
        for (int i = 0; i < lv; i++) begin
            ratio = (longint'(i) * 65536) / (lv - 1);
            // boost the low end: ratio below 3/10
            if (longint'(i) * 10 < (lv - 1) * 3) ratio = (ratio * 6) / 5;
            t = empty + (ratio * span) / 65536;
            if (t > full) t = full;
            thr_mv[i] = int'(t);
        end
        levels_latched = int'(lv);
        held_level = 0;
    endfunction

    // Advance the shadow state by one word and return the level it reports
    function automatic logic [3:0] quantize_word(logic op, logic [15:0] mv);
        int s, hit, h;
        s   = int'(mv);
        h   = int'(reg_hyst);
        hit = 0;
        if (op == OP_INIT) begin
            load_thresholds();
            return 4'd0;
        end
        // highest level above 0 whose threshold the sample reaches
        for (int i = 1; i < levels_latched; i++) begin
            if (s >= thr_mv[i]) hit = i;
        end
        // hold back a move that stays inside the hysteresis band
        if (hit > held_level) begin
            if (s <= thr_mv[hit] + h) hit = held_level;
        end else if (hit < held_level) begin
            if (s >= thr_mv[hit] - h) hit = held_level;
        end
        held_level = hit;
        return hit[3:0];
    endfunction

    function automatic plan_row_t mk_row(row_kind_t kind, logic [15:0] a, logic [15:0] b,
                                         logic fixed, logic [3:0] level);
        plan_row_t r;
        r.kind  = kind;
        r.arg_a = a;
        r.arg_b = b;
        r.fixed = fixed;
        r.level = level;
        return r;
    endfunction

    // Write one register; called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        case (addr)
            CFG_CELL_COUNT:  reg_cells  = value[CELL_W-1:0];
            CFG_LEVEL_COUNT: reg_levels = value[LVC_W-1:0];
            CFG_HYSTERESIS:  reg_hyst   = value[HYS_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one word after a random gap, record its level once taken
    task automatic send_word(input logic op, input logic [15:0] mv,
                             input logic fixed, input logic [3:0] fixed_level);
        logic [3:0] lvl;
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= mv;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        lvl = quantize_word(op, mv);
        pending_levels.push_back(fixed ? fixed_level : lvl);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every level word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_levels.size() != 0);
    endtask

    // Random backpressure on the result side
    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    // Compare each level word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("level word 0x%02h with nothing pending", m_tdata);
            end else begin
                level_want = pending_levels.pop_front();
                if (m_tdata !== {4'd0, level_want}) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("level mismatch: expected %0d, got 0x%02h", level_want, m_tdata);
                end
            end
        end
    end

    // Stop a hung run: count cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        plan_row_t   plan [$];
        plan_row_t   r;
        int          target, pick, k, h, mv_i, n_words;

        // reset values, extremes, band edges with zero hysteresis
        plan.push_back(mk_row(ROW_WORD, OP_INIT,     16'd0,     1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd0,     1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'hFFFF,  1'b1, 4'd1));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd0,     1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd4200,  1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd4201,  1'b1, 4'd1));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd2999,  1'b0, 4'd0));
        // zero cells, level count past the top, widest band, unused index
        plan.push_back(mk_row(ROW_CFG,  CFG_CELL_COUNT,  16'd0,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_LEVEL_COUNT, 16'd31,    1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_HYSTERESIS,  16'd4095,  1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_SPARE,       16'hFFF,   1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_INIT,     16'hFFFF,  1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'hFFFF,  1'b1, 4'd15));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd3000,  1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd0,     1'b0, 4'd0));
        // cell count past the top, level count of zero; old table still in use
        plan.push_back(mk_row(ROW_CFG,  CFG_CELL_COUNT,  16'd15,    1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_LEVEL_COUNT, 16'd0,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_HYSTERESIS,  16'd0,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd4199,  1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_INIT,     16'h5A5A,  1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd33601, 1'b1, 4'd1));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd24000, 1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd23999, 1'b1, 4'd0));
        // full pack, all sixteen levels, narrow band
        plan.push_back(mk_row(ROW_CFG,  CFG_CELL_COUNT,  16'd8,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_LEVEL_COUNT, 16'd16,    1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_HYSTERESIS,  16'd1,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_INIT,     16'd0,     1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd33602, 1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd26000, 1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd30000, 1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd25000, 1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd0,     1'b1, 4'd0));
        // cell count just past the top, level count of one
        plan.push_back(mk_row(ROW_CFG,  CFG_CELL_COUNT,  16'd9,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_LEVEL_COUNT, 16'd1,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_CFG,  CFG_HYSTERESIS,  16'd7,     1'b0, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_INIT,     16'd0,     1'b1, 4'd0));
        plan.push_back(mk_row(ROW_WORD, OP_CLASSIFY, 16'd33608, 1'b1, 4'd1));

        // hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed plan
        foreach (plan[j]) begin
            r = plan[j];
            if (r.kind == ROW_CFG) begin
                drain();
                write_reg(r.arg_a[CFG_A_W-1:0], r.arg_b[CFG_D_W-1:0]);
            end else begin
                send_word(r.arg_a[0], r.arg_b, r.fixed, r.level);
            end
        end

        // random phases: new settings while idle, then usually an init and a run of samples
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            drain();
            pick = $urandom_range(99);
            if (pick < 80)
                write_reg(CFG_CELL_COUNT, (pick < 8)  ? $urandom_range(15, 9) :
                                          (pick < 12) ? 0 : $urandom_range(8, 1));
            pick = $urandom_range(99);
            if (pick < 80)
                write_reg(CFG_LEVEL_COUNT, (pick < 8)  ? $urandom_range(31, 17) :
                                           (pick < 12) ? $urandom_range(1, 0) :
                                           (pick < 20) ? ($urandom_range(1, 0) ? 16 : 2) :
                                           $urandom_range(16, 2));
            pick = $urandom_range(99);
            if (pick < 80)
                write_reg(CFG_HYSTERESIS, (pick < 4)  ? 4095 :
                                          (pick < 15) ? $urandom_range(4095, 0) :
                                          (pick < 35) ? $urandom_range(600, 0) :
                                          $urandom_range(60, 0));
            if ($urandom_range(99) < 10) write_reg(CFG_SPARE, $urandom_range(4095, 0));
            if ($urandom_range(99) < 85) send_word(OP_INIT, $urandom_range(65535, 0), 1'b0, 4'd0);

            n_words = $urandom_range(60, 10);
            repeat (n_words) begin
                if ($urandom_range(99) < 4) begin
                    send_word(OP_INIT, $urandom_range(65535, 0), 1'b0, 4'd0);
                end else begin
                    pick = $urandom_range(99);
                    k    = $urandom_range(levels_latched - 1, 0);
                    h    = int'(reg_hyst);
                    if (pick < 15) begin
                        mv_i = int'($urandom_range(65535, 0));
                    end else if (pick < 60) begin
                        // land on or next to a band edge of one threshold
                        case ($urandom_range(4, 0))
                            0:       mv_i = thr_mv[k] - h - 1;
                            1:       mv_i = thr_mv[k] - h;
                            2:       mv_i = thr_mv[k] + h;
                            3:       mv_i = thr_mv[k] + h + 1;
                            default: mv_i = thr_mv[k] + int'($urandom_range(2 * h + 4, 0)) - h - 2;
                        endcase
                    end else begin
                        mv_i = int'($urandom_range(thr_mv[levels_latched - 1] + 300,
                                                   thr_mv[0] - 300));
                    end
                    if (mv_i < 0) mv_i = 0;
                    if (mv_i > 65535) mv_i = 65535;
                    send_word(OP_CLASSIFY, mv_i[15:0], 1'b0, 4'd0);
                end
            end
        end

        // let the last level words out, then allow for the block's latency
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
